>>> src/mscg_pkg.sv
// Shared types, constants and helpers for the multi-stop color gradient.
`timescale 1ns / 1ps

package mscg_pkg;

	localparam int STOP_COUNT = 16;
	localparam int IDX_W = $clog2(STOP_COUNT);
	localparam int CNT_W = $clog2(STOP_COUNT + 1);
	localparam int CHAN_W = 8;
	localparam int FRAC_BITS = 10;
	localparam int DIVIDEND_W = CHAN_W + FRAC_BITS;
	// Two quotient bits are retired per cycle.
	localparam int DIV_CYCLES = DIVIDEND_W / 2;
	localparam int STEP_W = $clog2(DIV_CYCLES + 1);
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_RESET = 5'd2;
	localparam logic [PC_W-1:0] PC_MIN = 5'd2;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] pos;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} stop_t;

	localparam int STOP_W = $bits(stop_t);

	typedef struct packed {
		opcode_t     opcode;
		logic [3:0]  stop_index;
		logic [7:0]  stop_pos;
		logic [7:0]  stop_red;
		logic [7:0]  stop_green;
		logic [7:0]  stop_blue;
		logic [7:0]  sample_pos;
	} req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} rsp_t;

	// Outcome of one segment search.
	typedef struct packed {
		logic  done;
		logic  s_found;
		logic  e_found;
		stop_t s_stop;
		stop_t e_stop;
	} scan_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_HOLD
	} state_t;

	// Contents of a table entry that was never written.
	function automatic stop_t reset_stop(logic [IDX_W-1:0] idx);
		stop_t s;
		s = (idx == IDX_W'(1)) ? '1 : '0;
		return s;
	endfunction

endpackage

>>> src/multi_stop_color_gradient.sv
// Top level of the multi-stop color gradient: stop table, control and result register.
`timescale 1ns / 1ps

// The request channel (req_valid, req_ready, req) carries one beat per item.
// A write beat stores one color stop in the table and gives no response. A
// sample beat looks up the segment around sample_pos and returns one
// response beat (rsp_valid, rsp_ready, rsp) with the color.
//
// A sample walks the active stops through the table RAM, one entry per
// cycle, then three channel lanes divide the scaled color difference by the
// segment length two quotient bits per cycle. A sample below the first stop
// or at or past the last one skips the divide. One item is worked at a time:
// req_ready is high only while the control is idle, so a sample holds the
// input until the control returns to idle. The response sits in an output
// register. If the receiver stalls, a new item can still be accepted and
// worked; a finished sample then waits until the register frees up. cfg_we
// writes point_count at once; the user must assert it only while idle,
// which the block does not enforce. Reset restores black at 0 and white at
// 255 as stops 0 and 1, the other stops to zero, and point_count to 2; no
// clearing pass is needed.

module multi_stop_color_gradient (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  mscg_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output mscg_pkg::rsp_t             rsp,
	input  logic                       cfg_we,
	input  logic [mscg_pkg::PC_W-1:0]  cfg_wdata
);

	mscg_pkg::state_t                  state_q;
	mscg_pkg::state_t                  state_d;
	logic [mscg_pkg::PC_W-1:0]         pc_q;
	logic [mscg_pkg::CNT_W-1:0]        active_n;
	logic [mscg_pkg::CHAN_W-1:0]       sample_q;
	logic [mscg_pkg::STOP_COUNT-1:0]   valid_q;
	logic [mscg_pkg::IDX_W-1:0]        rd_addr;
	logic [mscg_pkg::IDX_W-1:0]        rd_addr_s1;
	logic [mscg_pkg::STOP_W-1:0]       ram_rdata;
	mscg_pkg::stop_t                   rd_entry;
	mscg_pkg::stop_t                   wr_stop;
	mscg_pkg::scan_res_t               scan;
	mscg_pkg::rsp_t                    res_q;
	mscg_pkg::rsp_t                    rsp_q;
	logic                              rsp_valid_q;

	logic                              accept;
	logic                              wr_en;
	logic                              scan_start;
	logic                              lerp_start;
	logic                              direct;
	logic                              rsp_load;
	logic [2:0]                        lane_done;
	logic                              lanes_done;
	logic [mscg_pkg::CHAN_W-1:0]       span;
	logic [mscg_pkg::CHAN_W-1:0]       off;
	logic [mscg_pkg::CHAN_W-1:0]       lane_red;
	logic [mscg_pkg::CHAN_W-1:0]       lane_green;
	logic [mscg_pkg::CHAN_W-1:0]       lane_blue;
	mscg_pkg::stop_t                   edge_stop;

	assign req_ready = (state_q == mscg_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign wr_en     = accept && (req.opcode == mscg_pkg::OP_WRITE)
		&& (32'(req.stop_index) < mscg_pkg::STOP_COUNT);

	// Out-of-range stop counts act as the nearest legal value.
	always_comb begin
		if (pc_q < mscg_pkg::PC_MIN) begin
			active_n = mscg_pkg::CNT_W'(mscg_pkg::PC_MIN);
		end else if (32'(pc_q) > mscg_pkg::STOP_COUNT) begin
			active_n = mscg_pkg::CNT_W'(mscg_pkg::STOP_COUNT);
		end else begin
			active_n = mscg_pkg::CNT_W'(pc_q);
		end
	end

	assign wr_stop.pos   = req.stop_pos;
	assign wr_stop.red   = req.stop_red;
	assign wr_stop.green = req.stop_green;
	assign wr_stop.blue  = req.stop_blue;

	mscg_ram #(
		.WIDTH(mscg_pkg::STOP_W),
		.DEPTH(mscg_pkg::STOP_COUNT)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(mscg_pkg::IDX_W'(req.stop_index)),
		.wdata(wr_stop),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// An entry that was never written reads as its reset contents.
	assign rd_entry = valid_q[rd_addr_s1] ? mscg_pkg::stop_t'(ram_rdata)
		: mscg_pkg::reset_stop(rd_addr_s1);

	mscg_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.count     (active_n),
		.sample_pos(sample_q),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.res       (scan)
	);

	// All three lanes see the same segment geometry; the span is never zero here.
	assign span = scan.e_stop.pos - scan.s_stop.pos;
	assign off  = sample_q - scan.s_stop.pos;

	mscg_lerp u_lerp_red (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.a     (scan.s_stop.red),
		.b     (scan.e_stop.red),
		.span  (span),
		.off   (off),
		.done  (lane_done[0]),
		.color (lane_red)
	);

	mscg_lerp u_lerp_green (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.a     (scan.s_stop.green),
		.b     (scan.e_stop.green),
		.span  (span),
		.off   (off),
		.done  (lane_done[1]),
		.color (lane_green)
	);

	mscg_lerp u_lerp_blue (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.a     (scan.s_stop.blue),
		.b     (scan.e_stop.blue),
		.span  (span),
		.off   (off),
		.done  (lane_done[2]),
		.color (lane_blue)
	);

	assign lanes_done = &lane_done;

	// Below the first stop the search finds no start, and the lowest stop
	// serves; at or past the last stop it finds no end, and the start serves.
	assign edge_stop = scan.s_found ? scan.s_stop : scan.e_stop;

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		lerp_start = 1'b0;
		direct     = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			mscg_pkg::ST_IDLE: begin
				if (accept && req.opcode == mscg_pkg::OP_SAMPLE) begin
					scan_start = 1'b1;
					state_d    = mscg_pkg::ST_SCAN;
				end
			end
			mscg_pkg::ST_SCAN: begin
				if (scan.done) begin
					if (scan.s_found && scan.e_found) begin
						lerp_start = 1'b1;
						state_d    = mscg_pkg::ST_DIV;
					end else begin
						direct  = 1'b1;
						state_d = mscg_pkg::ST_HOLD;
					end
				end
			end
			mscg_pkg::ST_DIV: begin
				if (lanes_done) begin
					state_d = mscg_pkg::ST_HOLD;
				end
			end
			mscg_pkg::ST_HOLD: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = mscg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mscg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mscg_pkg::ST_IDLE;
			pc_q        <= mscg_pkg::PC_RESET;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[mscg_pkg::IDX_W'(req.stop_index)] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (scan_start) begin
			sample_q <= req.sample_pos;
		end
		if (direct) begin
			res_q.out_red   <= edge_stop.red;
			res_q.out_green <= edge_stop.green;
			res_q.out_blue  <= edge_stop.blue;
		end else if (state_q == mscg_pkg::ST_DIV && lanes_done) begin
			res_q.out_red   <= lane_red;
			res_q.out_green <= lane_green;
			res_q.out_blue  <= lane_blue;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// An accepted sample always moves the control into the table walk.
	a_sample_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.opcode == mscg_pkg::OP_SAMPLE)
		|=> (state_q == mscg_pkg::ST_SCAN))
		else $error("sample beat did not start the table walk");

	// The table walk reports completion only while the control waits for it.
	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan.done |-> (state_q == mscg_pkg::ST_SCAN))
		else $error("segment search finished outside the walk state");

	// The channel lanes finish together, and only during the divide phase.
	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done != 3'b000) |-> (lanes_done && state_q == mscg_pkg::ST_DIV))
		else $error("color lanes out of step or done outside divide phase");
`endif

endmodule

>>> src/mscg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mscg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/mscg_scan.sv
// Segment search: walks the active stops one per cycle and keeps the start and end stop.
`timescale 1ns / 1ps

module mscg_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mscg_pkg::CNT_W-1:0]    count,
	input  logic [mscg_pkg::CHAN_W-1:0]   sample_pos,
	output logic [mscg_pkg::IDX_W-1:0]    rd_addr,
	input  mscg_pkg::stop_t               rd_entry,
	output mscg_pkg::scan_res_t           res
);

	logic                        busy_q;
	logic [mscg_pkg::CNT_W-1:0]  cnt_q;
	logic                        rd_s1;
	logic                        last_s1;
	logic                        done_q;
	logic                        s_found_q;
	logic                        e_found_q;
	mscg_pkg::stop_t             s_q;
	mscg_pkg::stop_t             e_q;
	logic                        at_last;

	assign at_last = (cnt_q == mscg_pkg::CNT_W'(count - 1'b1));
	assign rd_addr = cnt_q[mscg_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			rd_s1     <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			s_found_q <= 1'b0;
			e_found_q <= 1'b0;
		end else begin
			rd_s1   <= busy_q;
			last_s1 <= busy_q && at_last;
			done_q  <= rd_s1 && last_s1;
			if (start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				s_found_q <= 1'b0;
				e_found_q <= 1'b0;
			end else begin
				if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (at_last) begin
						busy_q <= 1'b0;
					end
				end
				if (rd_s1) begin
					if (rd_entry.pos <= sample_pos) begin
						if (!s_found_q || rd_entry.pos >= s_q.pos) begin
							s_found_q <= 1'b1;
						end
					end else if (!e_found_q || rd_entry.pos < e_q.pos) begin
						e_found_q <= 1'b1;
					end
				end
			end
		end
	end

	// Candidate stops; a later index wins a tie at the start, an earlier one at the end.
	always_ff @(posedge clk) begin
		if (rd_s1 && !start) begin
			if (rd_entry.pos <= sample_pos) begin
				if (!s_found_q || rd_entry.pos >= s_q.pos) begin
					s_q <= rd_entry;
				end
			end else if (!e_found_q || rd_entry.pos < e_q.pos) begin
				e_q <= rd_entry;
			end
		end
	end

	assign res.done    = done_q;
	assign res.s_found = s_found_q;
	assign res.e_found = e_found_q;
	assign res.s_stop  = s_q;
	assign res.e_stop  = e_q;

endmodule

>>> src/mscg_lerp.sv
// One color channel: digit-serial division of the scaled difference, fused with the offset multiply.
`timescale 1ns / 1ps

module mscg_lerp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mscg_pkg::CHAN_W-1:0] a,
	input  logic [mscg_pkg::CHAN_W-1:0] b,
	input  logic [mscg_pkg::CHAN_W-1:0] span,
	input  logic [mscg_pkg::CHAN_W-1:0] off,
	output logic                        done,
	output logic [mscg_pkg::CHAN_W-1:0] color
);

	localparam int CW = mscg_pkg::CHAN_W;
	localparam int DW = mscg_pkg::DIVIDEND_W;
	localparam int FB = mscg_pkg::FRAC_BITS;

	logic                            busy_q;
	logic                            done_q;
	logic [mscg_pkg::STEP_W-1:0]     cnt_q;
	logic                            neg_q;
	logic [CW-1:0]                   a_q;
	logic [CW-1:0]                   span_q;
	logic [CW-1:0]                   off_q;
	logic [CW-1:0]                   r_q;
	logic [DW-1:0]                   div_q;
	logic [DW-1:0]                   acc_q;

	logic                            neg;
	logic [CW-1:0]                   mag;
	logic [CW:0]                     r1;
	logic [CW:0]                     r1n;
	logic [CW:0]                     r2;
	logic [CW:0]                     r2n;
	logic                            ge1;
	logic                            ge2;
	logic [DW-1:0]                   acc_nx;
	logic [DW:0]                     base;
	logic [DW:0]                     v;

	assign neg = (b < a);
	assign mag = neg ? (a - b) : (b - a);

	// Two restoring steps per cycle; each quotient bit folds into the
	// running product off * quotient, most significant bit first.
	always_comb begin
		r1     = {r_q, div_q[DW-1]};
		ge1    = (r1 >= {1'b0, span_q});
		r1n    = ge1 ? (r1 - {1'b0, span_q}) : r1;
		r2     = {r1n[CW-1:0], div_q[DW-2]};
		ge2    = (r2 >= {1'b0, span_q});
		r2n    = ge2 ? (r2 - {1'b0, span_q}) : r2;
		acc_nx = {acc_q[DW-3:0], 2'b00}
			+ (ge1 ? DW'({off_q, 1'b0}) : DW'(0))
			+ (ge2 ? DW'(off_q) : DW'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mscg_pkg::STEP_W'(mscg_pkg::DIV_CYCLES);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mscg_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= neg;
			a_q    <= a;
			span_q <= span;
			off_q  <= off;
			r_q    <= '0;
			div_q  <= {mag, FB'(0)};
			acc_q  <= '0;
		end else if (busy_q) begin
			r_q   <= r2n[CW-1:0];
			div_q <= {div_q[DW-3:0], 2'b00};
			acc_q <= acc_nx;
		end
	end

	assign base  = {1'b0, a_q, FB'(0)};
	assign v     = neg_q ? (base - {1'b0, acc_q}) : (base + {1'b0, acc_q});
	assign color = v[DW-1:FB];
	assign done  = done_q;

endmodule
